// ===== src/bpa_pkg.sv =====
// shared constants, types and state encoding for the buddy page allocator
// no dependencies
package bpa_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int NUM_ORDERS = 10;
    localparam int PAGE_W     = 12;
    localparam int LINK_W     = 13;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = 13;
    localparam int PAIR_DEPTH = NUM_PAGES / 2;
    localparam int ROW_W      = 11;

    localparam logic [LINK_W-1:0] NIL        = LINK_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0]  ZONE_RESET = CNT_W'(NUM_PAGES);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_BLOCK  = 2'd1,
        ST_MISALIGN  = 2'd2,
        ST_RANGE     = 2'd3
    } bpa_status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } bpa_action_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_UL_RD,
        S_UL_WR,
        S_FL_RD,
        S_FL_WR,
        S_PS_WR1,
        S_PS_WR2,
        S_RESP
    } bpa_state_t;

endpackage

// ===== src/buddy_page_allocator.sv =====
// binary buddy page allocator, top level
// depends on bpa_pkg and bpa_ram
//
// One zone of 4096 pages with block orders 0..9. Each order keeps a LIFO free
// list doubly linked through two link memories, plus one toggle bit per buddy
// pair held in a pair memory (one row of ten bits per pair index). After reset
// the pair memory is swept to zero, one row a cycle over all 2048 rows, during
// which no word is taken on s_; configuration writes are taken at any time.
// The zone starts fully allocated (free count zero). One request is worked at
// a time as a sequence of memory read/modify/write steps: accept and classify,
// then on allocate the unlink plus pair toggle of the source block and, per
// split level, a push then a toggle; a free does a toggle plus unlink of the
// buddy per merge level, then the last toggle (none at order 9) and the push.
// Every request ends by loading the result, which waits while the previous
// result still waits on m_; the steps follow from the one-read-one-write ports
// of the link and pair memories.
// A new word is accepted while a previous result still waits on m_.
// Errors come back as status codes with block_index zero.
module buddy_page_allocator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [3:0]                s_order,
    input  logic [11:0]               s_page_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [11:0]               m_block_index,
    output logic [12:0]               m_free_count,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [12:0]               cfg_data
);

    // state and request context
    bpa_pkg::bpa_state_t state_reg, state_next;
    logic                           act_reg, act_next;
    logic [bpa_pkg::ORD_W-1:0]      ord_reg, ord_next;
    logic [bpa_pkg::ORD_W-1:0]      lvl_reg, lvl_next;
    logic [bpa_pkg::LINK_W-1:0]     pg_reg, pg_next;
    logic [bpa_pkg::PAGE_W-1:0]     ul_addr_reg, ul_addr_next;
    logic                           split_reg, split_next;
    logic [1:0]                     status_reg, status_next;
    logic [bpa_pkg::LINK_W-1:0]     head_reg [bpa_pkg::NUM_ORDERS];
    logic [bpa_pkg::LINK_W-1:0]     head_next [bpa_pkg::NUM_ORDERS];
    logic [bpa_pkg::CNT_W-1:0]      free_total_reg, free_total_next;
    logic [bpa_pkg::CNT_W-1:0]      zone_reg;
    logic [bpa_pkg::ROW_W:0]        clr_cnt_reg;

    // result register
    logic                           m_valid_reg;
    logic [1:0]                     m_status_reg;
    logic [bpa_pkg::PAGE_W-1:0]     m_block_reg;
    logic [bpa_pkg::CNT_W-1:0]      m_free_reg;
    logic                           res_load;

    // memory ports
    logic                           nx_we, pv_we, pr_we;
    logic [bpa_pkg::PAGE_W-1:0]     nx_waddr, pv_waddr;
    logic [bpa_pkg::LINK_W-1:0]     nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [bpa_pkg::ROW_W-1:0]      pr_waddr, pr_raddr;
    logic [bpa_pkg::NUM_ORDERS-1:0] pr_wdata, pr_rdata;

    // helpers
    logic                           found;
    logic [bpa_pkg::ORD_W-1:0]      found_lvl;
    logic [bpa_pkg::LINK_W-1:0]     n_c, p_c;
    logic [bpa_pkg::LINK_W-1:0]     pg_shift;
    logic [bpa_pkg::CNT_W:0]        size14, end14;
    logic                           old_bit;
    logic [bpa_pkg::ORD_W-1:0]      lvl_up;
    logic [bpa_pkg::LINK_W-1:0]     cur_head;

    bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::NUM_PAGES)) u_next_ram (
        .aclk(aclk), .wr_en(nx_we), .wr_addr(nx_waddr), .wr_data(nx_wdata),
        .rd_addr(ul_addr_reg), .rd_data(nx_rdata)
    );

    bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::NUM_PAGES)) u_prev_ram (
        .aclk(aclk), .wr_en(pv_we), .wr_addr(pv_waddr), .wr_data(pv_wdata),
        .rd_addr(ul_addr_reg), .rd_data(pv_rdata)
    );

    bpa_ram #(.WIDTH(bpa_pkg::NUM_ORDERS), .DEPTH(bpa_pkg::PAIR_DEPTH)) u_pair_ram (
        .aclk(aclk), .wr_en(pr_we), .wr_addr(pr_waddr), .wr_data(pr_wdata),
        .rd_addr(pr_raddr), .rd_data(pr_rdata)
    );

    function automatic logic ORD_OK(input int c);
        return c >= int'(ord_reg);
    endfunction

    // first non-empty list at or above the requested order
    always_comb begin
        found     = 1'b0;
        found_lvl = '0;
        for (int c = bpa_pkg::NUM_ORDERS - 1; c >= 0; c--) begin
            if (ORD_OK(c) && head_reg[c] < bpa_pkg::NIL) begin
                found     = 1'b1;
                found_lvl = bpa_pkg::ORD_W'(c);
            end
        end
    end

    // unlink operands, clamped to none
    assign n_c = (nx_rdata >= bpa_pkg::NIL) ? bpa_pkg::NIL : nx_rdata;
    assign p_c = (pv_rdata >= bpa_pkg::NIL) ? bpa_pkg::NIL : pv_rdata;

    // pair row of the current block at the current order
    assign pg_shift = pg_reg >> (lvl_reg + 4'd1);
    assign pr_raddr = pg_shift[bpa_pkg::ROW_W-1:0];
    assign old_bit  = pr_rdata[lvl_reg];
    assign lvl_up   = lvl_reg + 4'd1;
    assign cur_head = head_reg[lvl_reg];

    // free range check in 14 bits
    assign size14 = (bpa_pkg::CNT_W+1)'(1) << ord_reg;
    assign end14  = {2'b00, pg_reg[bpa_pkg::PAGE_W-1:0]} + size14;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::S_CLEAR: begin
                if (clr_cnt_reg[bpa_pkg::ROW_W]) state_next = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_IDLE: begin
                if (s_valid) state_next = bpa_pkg::S_CHECK;
            end
            bpa_pkg::S_CHECK: begin
                if (act_reg == bpa_pkg::ACT_ALLOC) begin
                    state_next = found ? bpa_pkg::S_UL_RD : bpa_pkg::S_RESP;
                end else if (ord_reg >= bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS)
                             || (pg_reg[bpa_pkg::PAGE_W-1:0]
                                 & bpa_pkg::PAGE_W'(size14 - 1'b1)) != '0
                             || end14 > {1'b0, zone_reg}
                             || end14 > (bpa_pkg::CNT_W+1)'(bpa_pkg::NUM_PAGES)) begin
                    state_next = bpa_pkg::S_RESP;
                end else if (ord_reg < bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS - 1)) begin
                    state_next = bpa_pkg::S_FL_RD;
                end else begin
                    state_next = bpa_pkg::S_PS_WR1;
                end
            end
            bpa_pkg::S_UL_RD: state_next = bpa_pkg::S_UL_WR;
            bpa_pkg::S_UL_WR: begin
                if (act_reg == bpa_pkg::ACT_ALLOC
                    || lvl_up < bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS - 1)) begin
                    state_next = bpa_pkg::S_FL_RD;
                end else begin
                    state_next = bpa_pkg::S_PS_WR1;
                end
            end
            bpa_pkg::S_FL_RD: state_next = bpa_pkg::S_FL_WR;
            bpa_pkg::S_FL_WR: begin
                if (act_reg == bpa_pkg::ACT_ALLOC) begin
                    state_next = (lvl_reg > ord_reg) ? bpa_pkg::S_PS_WR1 : bpa_pkg::S_RESP;
                end else begin
                    state_next = old_bit ? bpa_pkg::S_UL_RD : bpa_pkg::S_PS_WR1;
                end
            end
            bpa_pkg::S_PS_WR1: state_next = bpa_pkg::S_PS_WR2;
            bpa_pkg::S_PS_WR2: begin
                state_next = (act_reg == bpa_pkg::ACT_ALLOC) ? bpa_pkg::S_FL_RD
                                                             : bpa_pkg::S_RESP;
            end
            bpa_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) state_next = bpa_pkg::S_IDLE;
            end
            default: state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        act_next        = act_reg;
        ord_next        = ord_reg;
        lvl_next        = lvl_reg;
        pg_next         = pg_reg;
        ul_addr_next    = ul_addr_reg;
        split_next      = split_reg;
        status_next     = status_reg;
        free_total_next = free_total_reg;
        for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) head_next[i] = head_reg[i];
        nx_we    = 1'b0;
        nx_waddr = pg_reg[bpa_pkg::PAGE_W-1:0];
        nx_wdata = cur_head;
        pv_we    = 1'b0;
        pv_waddr = pg_reg[bpa_pkg::PAGE_W-1:0];
        pv_wdata = bpa_pkg::NIL;
        pr_we    = 1'b0;
        pr_waddr = pr_raddr;
        pr_wdata = pr_rdata ^ (bpa_pkg::NUM_ORDERS'(1) << lvl_reg);
        res_load = 1'b0;

        unique case (state_reg)
            bpa_pkg::S_CLEAR: begin
                pr_we    = ~clr_cnt_reg[bpa_pkg::ROW_W];
                pr_waddr = clr_cnt_reg[bpa_pkg::ROW_W-1:0];
                pr_wdata = '0;
            end
            bpa_pkg::S_IDLE: begin
                act_next    = s_action;
                ord_next    = s_order;
                pg_next     = {1'b0, s_page_index};
                split_next  = 1'b0;
                status_next = bpa_pkg::ST_OK;
            end
            bpa_pkg::S_CHECK: begin
                if (act_reg == bpa_pkg::ACT_ALLOC) begin
                    if (found) begin
                        lvl_next        = found_lvl;
                        pg_next         = head_reg[found_lvl];
                        ul_addr_next    = head_reg[found_lvl][bpa_pkg::PAGE_W-1:0];
                        free_total_next = free_total_reg
                                          - (bpa_pkg::CNT_W'(1) << ord_reg);
                    end else begin
                        status_next = bpa_pkg::ST_NO_BLOCK;
                        pg_next     = '0;
                    end
                end else if (ord_reg >= bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS)) begin
                    status_next = bpa_pkg::ST_RANGE;
                    pg_next     = '0;
                end else if ((pg_reg[bpa_pkg::PAGE_W-1:0]
                              & bpa_pkg::PAGE_W'(size14 - 1'b1)) != '0) begin
                    status_next = bpa_pkg::ST_MISALIGN;
                    pg_next     = '0;
                end else if (end14 > {1'b0, zone_reg}
                             || end14 > (bpa_pkg::CNT_W+1)'(bpa_pkg::NUM_PAGES)) begin
                    status_next = bpa_pkg::ST_RANGE;
                    pg_next     = '0;
                end else begin
                    lvl_next        = ord_reg;
                    free_total_next = free_total_reg + bpa_pkg::CNT_W'(size14);
                end
            end
            bpa_pkg::S_UL_WR: begin
                // unlink: predecessor or head takes the successor
                if (p_c < bpa_pkg::NIL) begin
                    nx_we    = 1'b1;
                    nx_waddr = p_c[bpa_pkg::PAGE_W-1:0];
                    nx_wdata = n_c;
                end else begin
                    head_next[lvl_reg] = n_c;
                end
                if (n_c < bpa_pkg::NIL) begin
                    pv_we    = 1'b1;
                    pv_waddr = n_c[bpa_pkg::PAGE_W-1:0];
                    pv_wdata = p_c;
                end
                if (act_reg == bpa_pkg::ACT_FREE) begin
                    lvl_next = lvl_up;
                    pg_next  = pg_reg & ~((bpa_pkg::LINK_W'(1) << lvl_up) - 1'b1);
                end
            end
            bpa_pkg::S_FL_WR: begin
                pr_we = 1'b1;
                if (act_reg == bpa_pkg::ACT_ALLOC) begin
                    // after a split push the upper half moves on
                    if (split_reg) pg_next = pg_reg + (bpa_pkg::LINK_W'(1) << lvl_reg);
                    if (lvl_reg > ord_reg) begin
                        lvl_next   = lvl_reg - 4'd1;
                        split_next = 1'b1;
                    end
                end else begin
                    ul_addr_next = pg_reg[bpa_pkg::PAGE_W-1:0]
                                   ^ (bpa_pkg::PAGE_W'(1) << lvl_reg);
                end
            end
            bpa_pkg::S_PS_WR1: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            bpa_pkg::S_PS_WR2: begin
                if (cur_head < bpa_pkg::NIL) begin
                    pv_we    = 1'b1;
                    pv_waddr = cur_head[bpa_pkg::PAGE_W-1:0];
                    pv_wdata = {1'b0, pg_reg[bpa_pkg::PAGE_W-1:0]};
                end
                head_next[lvl_reg] = {1'b0, pg_reg[bpa_pkg::PAGE_W-1:0]};
            end
            bpa_pkg::S_RESP: begin
                res_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bpa_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            free_total_reg <= '0;
            zone_reg       <= bpa_pkg::ZONE_RESET;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) head_reg[i] <= bpa_pkg::NIL;
        end else begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) head_reg[i] <= head_next[i];
            if (state_reg == bpa_pkg::S_CLEAR && !clr_cnt_reg[bpa_pkg::ROW_W]) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid) zone_reg <= cfg_data;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        ord_reg     <= ord_next;
        lvl_reg     <= lvl_next;
        pg_reg      <= pg_next;
        ul_addr_reg <= ul_addr_next;
        split_reg   <= split_next;
        status_reg  <= status_next;
        if (res_load) begin
            m_status_reg <= status_reg;
            m_block_reg  <= pg_reg[bpa_pkg::PAGE_W-1:0];
            m_free_reg   <= free_total_reg;
        end
    end

    assign s_ready       = (state_reg == bpa_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_block_index = m_block_reg;
    assign m_free_count  = m_free_reg;

endmodule

// ===== src/bpa_ram.sv =====
// simple dual port ram, one write port and one registered read port
// no dependencies
module bpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/bpa_checker.sv =====
// port level checks for the buddy page allocator, bound to the top level
// depends on bpa_pkg and buddy_page_allocator
module bpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [11:0] m_block_index,
    input logic [12:0] m_free_count
);

    // a result waiting on the output holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_block_index) && $stable(m_free_count))
        else $error("stalled result changed");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word taken while busy");

    // failed requests carry no block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != bpa_pkg::ST_OK |-> m_block_index == '0)
        else $error("error result with block index");

    // no result appears right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid out of reset");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
